// ===== sv/wmc_pkg.sv =====
// Shared types and constants for the wheel motor command controller.
`default_nettype none
package wmc_pkg;

  localparam int NUM_REGS    = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int ID_W        = 29;
  localparam int WHEEL_IDX_W = 2;

  typedef logic [ID_W-1:0]         id_t;
  typedef logic signed [15:0]      speed_t;
  typedef logic signed [31:0]      position_t;
  typedef logic [7:0]              status_t;
  typedef logic [CFG_IDX_W-1:0]    reg_idx_t;

  typedef enum logic [2:0] {
    FUNC_SET_SPEED = 3'd0,
    FUNC_STOP      = 3'd1,
    FUNC_ESTOP     = 3'd2,
    FUNC_TICK      = 3'd3,
    FUNC_FEEDBACK  = 3'd4,
    FUNC_HEARTBEAT = 3'd5
  } func_t;

  localparam reg_idx_t REG_FRONT_LEFT  = 2'd0;
  localparam reg_idx_t REG_FRONT_RIGHT = 2'd1;
  localparam reg_idx_t REG_REAR_LEFT   = 2'd2;
  localparam reg_idx_t REG_REAR_RIGHT  = 2'd3;

  localparam id_t ID_RESET_FL = 29'h100;
  localparam id_t ID_RESET_FR = 29'h101;
  localparam id_t ID_RESET_RL = 29'h102;
  localparam id_t ID_RESET_RR = 29'h103;

  localparam id_t FB_FIRST = 29'h110;
  localparam id_t FB_LAST  = 29'h113;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] wheel_index;
    speed_t     wanted_speed;
    id_t        rx_frame_id;
    status_t    rx_status;
    position_t  rx_position;
  } evt_t;

  // Request from the mode controller to the wheel scanner.
  typedef struct packed {
    logic                   start;
    logic                   all;
    logic [WHEEL_IDX_W-1:0] wheel;
    logic                   enable;
  } scan_cmd_t;

endpackage
`default_nettype wire

// ===== sv/wmc_if.sv =====
// Event and command frame channel interfaces.
`default_nettype none
interface wmc_evt_if;
  import wmc_pkg::*;
  logic      valid;
  logic      ready;
  logic [2:0] func;
  logic [7:0] wheel_index;
  speed_t    wanted_speed;
  id_t       rx_frame_id;
  status_t   rx_status;
  position_t rx_position;

  modport source (output valid, func, wheel_index, wanted_speed, rx_frame_id, rx_status,
                  rx_position, input ready);
  modport sink (input valid, func, wheel_index, wanted_speed, rx_frame_id, rx_status,
                rx_position, output ready);
endinterface

interface wmc_frame_if;
  import wmc_pkg::*;
  logic   valid;
  logic   ready;
  id_t    frame_id;
  speed_t frame_speed;
  logic   frame_enable;
  logic   last;

  modport source (output valid, frame_id, frame_speed, frame_enable, last, input ready);
  modport sink (input valid, frame_id, frame_speed, frame_enable, last, output ready);
endinterface
`default_nettype wire

// ===== sv/wmc_ctrl.sv =====
// Mode controller: event decode, mode, latches and per-wheel storage.
`default_nettype none
module wmc_ctrl #(
  parameter int WHEEL_COUNT = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire wmc_pkg::evt_t      evt,
  output wmc_pkg::scan_cmd_t      cmd,
  output wmc_pkg::speed_t         speed [WHEEL_COUNT]
);
  import wmc_pkg::*;

  localparam int IdxW = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_STOPPED = 2'd2
  } mode_t;

  mode_t     mode, mode_next;
  logic      latched, latched_next;
  logic      enable_flag, enable_next;
  logic      spd_we, spd_zero, fb_we;
  logic      w_ok, fb_ok;
  logic [IdxW-1:0] widx, fidx;
  status_t   status   [WHEEL_COUNT];
  position_t position [WHEEL_COUNT];

  assign w_ok  = evt.wheel_index < 8'(WHEEL_COUNT);
  assign widx  = evt.wheel_index[IdxW-1:0];
  assign fb_ok = (evt.rx_frame_id >= FB_FIRST) && (evt.rx_frame_id <= FB_LAST) &&
                 ({1'b0, evt.rx_frame_id[1:0]} < 3'(WHEEL_COUNT));
  assign fidx  = IdxW'(evt.rx_frame_id[1:0]);

  always_comb begin
    mode_next    = mode;
    latched_next = latched;
    enable_next  = enable_flag;
    spd_we       = 1'b0;
    spd_zero     = 1'b0;
    fb_we        = 1'b0;
    cmd          = '0;
    cmd.wheel    = WHEEL_IDX_W'(widx);
    case (mode)
      MODE_RUNNING: begin
        case (func_t'(evt.func))
          FUNC_SET_SPEED: begin
            if (w_ok) begin
              spd_we     = 1'b1;
              cmd.start  = 1'b1;
              cmd.enable = enable_flag;
            end
          end
          FUNC_STOP, FUNC_ESTOP: begin
            if (func_t'(evt.func) == FUNC_ESTOP) latched_next = 1'b1;
            spd_zero    = 1'b1;
            cmd.start   = 1'b1;
            cmd.all     = 1'b1;
            cmd.enable  = enable_flag;
            enable_next = 1'b0;
            mode_next   = MODE_STOPPED;
          end
          FUNC_TICK: begin
            cmd.start  = 1'b1;
            cmd.all    = 1'b1;
            cmd.enable = enable_flag;
          end
          FUNC_FEEDBACK: fb_we = fb_ok;
          default: ;
        endcase
      end
      MODE_STOPPED: begin
        case (func_t'(evt.func))
          FUNC_SET_SPEED: begin
            if (!latched) begin
              mode_next   = MODE_RUNNING;
              enable_next = 1'b1;
              cmd.start   = 1'b1;
              cmd.all     = 1'b1;
              cmd.enable  = 1'b1;
            end
          end
          FUNC_HEARTBEAT: begin
            latched_next = 1'b0;
            mode_next    = MODE_IDLE;
            enable_next  = 1'b0;
          end
          default: ;
        endcase
      end
      default: begin
        if (func_t'(evt.func) == FUNC_SET_SPEED) begin
          spd_we      = w_ok;
          mode_next   = MODE_RUNNING;
          enable_next = 1'b1;
          cmd.start   = 1'b1;
          cmd.all     = 1'b1;
          cmd.enable  = 1'b1;
        end
      end
    endcase
    cmd.start = cmd.start & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      latched     <= 1'b0;
      enable_flag <= 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        speed[i]    <= '0;
        status[i]   <= '0;
        position[i] <= '0;
      end
    end else if (accept) begin
      mode        <= mode_next;
      latched     <= latched_next;
      enable_flag <= enable_next;
      if (spd_zero) begin
        for (int i = 0; i < WHEEL_COUNT; i++) speed[i] <= '0;
      end else if (spd_we) begin
        speed[widx] <= evt.wanted_speed;
      end
      if (fb_we) begin
        status[fidx]   <= evt.rx_status;
        position[fidx] <= evt.rx_position;
      end
    end
  end

`ifndef SYNTHESIS
  a_latch_stopped: assert property (@(posedge clk) disable iff (rst)
    latched |-> mode == MODE_STOPPED) else $error("latch set outside stopped mode");
  a_enable_running: assert property (@(posedge clk) disable iff (rst)
    enable_flag == (mode == MODE_RUNNING)) else $error("enable flag out of step with mode");
  a_stop_enters_stopped: assert property (@(posedge clk) disable iff (rst)
    (accept && spd_zero) |=> mode == MODE_STOPPED && !enable_flag)
    else $error("stop did not reach stopped mode");
`endif

endmodule
`default_nettype wire

// ===== sv/wmc_scan.sv =====
// Wheel scanner: sends pending wheels one command frame per cycle unless stalled.
`default_nettype none
module wmc_scan #(
  parameter int WHEEL_COUNT = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wmc_pkg::scan_cmd_t cmd,
  input  wire wmc_pkg::speed_t    speed [WHEEL_COUNT],
  input  wire wmc_pkg::id_t       ids   [WHEEL_COUNT],
  output logic                    busy,
  wmc_frame_if.source             frame
);
  import wmc_pkg::*;

  localparam int IdxW = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  logic [WHEEL_COUNT-1:0] pend, mask, nz, sel;
  logic [IdxW-1:0]        idx;
  logic                   en_q, emit, last_sel;
  logic                   out_valid, out_enable, out_last;
  id_t                    out_id;
  speed_t                 out_speed;

  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) nz[i] = ids[i] != '0;
    mask = cmd.all ? '1 : (WHEEL_COUNT'(1) << cmd.wheel);
    idx  = '0;
    for (int i = WHEEL_COUNT - 1; i >= 0; i--) begin
      if (pend[i]) idx = IdxW'(i);
    end
    sel      = WHEEL_COUNT'(1) << idx;
    last_sel = (pend & ~sel) == '0;
    emit     = (pend != '0) && (!out_valid || frame.ready);
  end

  assign busy = pend != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !frame.ready);
      if (cmd.start) begin
        pend <= mask & nz;
        en_q <= cmd.enable;
      end else if (emit) begin
        out_id     <= ids[idx];
        out_speed  <= speed[idx];
        out_enable <= en_q;
        out_last   <= last_sel;
        pend       <= pend & ~sel;
      end
    end
  end

  assign frame.valid        = out_valid;
  assign frame.frame_id     = out_id;
  assign frame.frame_speed  = out_speed;
  assign frame.frame_enable = out_enable;
  assign frame.last         = out_last;

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> pend == '0) else $error("scan started while busy");
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (emit && last_sel) |=> pend == '0) else $error("wheels left after last frame");
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (emit && !last_sel) |=> pend != '0) else $error("frame not marked last with none left");
`endif

endmodule
`default_nettype wire

// ===== sv/wheel_motor_command_fsm.sv =====
// Top level of the wheel motor command controller.
// An accepted event loads the scanner's pending wheel set; frames are registered outputs.
// Events are not accepted while the scanner has wheels pending; the scanner issues one
// wheel frame per cycle while the output is not stalled.
// Frame identifiers of zero are skipped.
// Reset (synchronous, active high) returns to idle mode with speeds and feedback cleared.
`default_nettype none
module wheel_motor_command_fsm #(
  parameter int WHEEL_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire wmc_pkg::reg_idx_t cfg_index,
  input  wire wmc_pkg::id_t      cfg_data,
  wmc_evt_if.sink                evt,
  wmc_frame_if.source            frame
);
  import wmc_pkg::*;

  id_t       frame_ids [NUM_REGS];
  id_t       ids       [WHEEL_COUNT];
  speed_t    speed     [WHEEL_COUNT];
  evt_t      evt_data;
  scan_cmd_t cmd;
  logic      busy, accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ids[REG_FRONT_LEFT]  <= ID_RESET_FL;
      frame_ids[REG_FRONT_RIGHT] <= ID_RESET_FR;
      frame_ids[REG_REAR_LEFT]   <= ID_RESET_RL;
      frame_ids[REG_REAR_RIGHT]  <= ID_RESET_RR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRONT_LEFT:  frame_ids[REG_FRONT_LEFT]  <= cfg_data;
        REG_FRONT_RIGHT: frame_ids[REG_FRONT_RIGHT] <= cfg_data;
        REG_REAR_LEFT:   frame_ids[REG_REAR_LEFT]   <= cfg_data;
        REG_REAR_RIGHT:  frame_ids[REG_REAR_RIGHT]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) ids[i] = frame_ids[i];
  end

  assign evt.ready = !busy;
  assign accept    = evt.valid && !busy;

  assign evt_data.func         = evt.func;
  assign evt_data.wheel_index  = evt.wheel_index;
  assign evt_data.wanted_speed = evt.wanted_speed;
  assign evt_data.rx_frame_id  = evt.rx_frame_id;
  assign evt_data.rx_status    = evt.rx_status;
  assign evt_data.rx_position  = evt.rx_position;

  wmc_ctrl #(.WHEEL_COUNT(WHEEL_COUNT)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .evt    (evt_data),
    .cmd    (cmd),
    .speed  (speed)
  );

  wmc_scan #(.WHEEL_COUNT(WHEEL_COUNT)) u_scan (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .speed (speed),
    .ids   (ids),
    .busy  (busy),
    .frame (frame)
  );

endmodule
`default_nettype wire
